FILE: design/http_header_tokenizer_core_defines.svh
// assertion macros shared by the tokenizer modules
// expects clk and rst_n to be visible in the module that uses them
`ifndef HTTP_HEADER_TOKENIZER_CORE_DEFINES_SVH
`define HTTP_HEADER_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HTT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/htt_pkg.sv
// shared types and constants of the http header tokenizer
// no dependencies
package htt_pkg;

    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam logic [15:0] MAX_OFFSET = 16'(MAX_MESSAGE_BYTES - 1);

    // result queue between parser and output stage
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        TK_METHOD   = 4'd0,
        TK_URI      = 4'd1,
        TK_VERSION  = 4'd2,
        TK_STATUS   = 4'd3,
        TK_REASON   = 4'd4,
        TK_NAME     = 4'd5,
        TK_VALUE    = 4'd6,
        TK_ACC_REQ  = 4'd7,
        TK_ACC_RSP  = 4'd8,
        TK_REJECT   = 4'd9
    } token_kind_t;

    typedef enum logic [4:0] {
        PH_START,
        PH_METHOD,
        PH_SP_URI,
        PH_URI,
        PH_SP_VER,
        PH_VERSION,
        PH_START_LF,
        PH_SP_STATUS,
        PH_STATUS,
        PH_SP_REASON,
        PH_REASON,
        PH_NAME_START,
        PH_NAME,
        PH_VALUE_START,
        PH_VALUE,
        PH_LINE_LF,
        PH_HEAD_LF
    } phase_t;

    typedef struct packed {
        token_kind_t  kind;
        logic [15:0]  start;
        logic [15:0]  length;
    } result_t;

    // all results caused by one byte, cnt is 0 to 3; only bundles with cnt 1 to 3 are pushed
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    cnt;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic result_t mk_result(token_kind_t k, logic [15:0] s, logic [15:0] l);
        result_t r;
        r.kind   = k;
        r.start  = s;
        r.length = l;
        return r;
    endfunction

endpackage

FILE: design/htt_front.sv
// parser front end: accepts message bytes and turns each into a bundle of results
// depends on htt_pkg
module htt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               first_byte,
    input  logic               last_byte,
    input  logic               kind,
    input  htt_pkg::q_status_t q_status,
    output logic               push,
    output htt_pkg::bundle_t   bundle
);
    import htt_pkg::*;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] VERSION_TEXT [8] = '{8'h48, 8'h54, 8'h54, 8'h50,
                                                 8'h2F, 8'h31, 8'h2E, 8'h31};

    phase_t      phase_reg, phase_next;
    logic        kind_reg, kind_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] tok_begin_reg, tok_begin_next;
    logic [15:0] name_begin_reg, name_begin_next;
    logic [15:0] name_end_reg, name_end_next;
    logic [15:0] val_begin_reg, val_begin_next;
    logic [15:0] val_end_reg, val_end_next;
    logic [3:0]  vmc_reg, vmc_next;
    logic        vmm_reg, vmm_next;
    logic        finished_reg, finished_next;

    phase_t      cur_phase;
    logic        cur_kind;
    logic [15:0] off;
    logic [3:0]  cur_vmc;
    logic        cur_vmm;
    logic        take;
    logic        done;
    logic        extra_rej;
    logic [1:0]  pcnt;
    result_t     res0, res1;
    logic [3:0]  feed_vmc;
    logic        feed_vmm;
    logic        is_upper, is_digit, ver_ok;

    assign in_ready = !q_status.full;
    assign take     = in_valid && in_ready && (first_byte || !finished_reg);

    // a first byte restarts the parse from a clean context
    assign cur_phase = first_byte ? PH_START : phase_reg;
    assign cur_kind  = first_byte ? kind : kind_reg;
    assign off       = first_byte ? 16'd0 : offset_reg;
    assign cur_vmc   = first_byte ? 4'd0 : vmc_reg;
    assign cur_vmm   = first_byte ? 1'b0 : vmm_reg;

    assign is_upper = data_byte inside {[CH_A:CH_Z]};
    assign is_digit = data_byte inside {[CH_0:CH_9]};
    assign ver_ok   = !cur_vmm && (cur_vmc == 4'd8);

    // version prefix match, one byte further
    always_comb
    begin
        feed_vmc = cur_vmc;
        feed_vmm = cur_vmm;
        if (!cur_vmm && (cur_vmc < 4'd8))
        begin
            if (data_byte == VERSION_TEXT[cur_vmc[2:0]])
                feed_vmc = cur_vmc + 4'd1;
            else
                feed_vmm = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            kind_reg       <= 1'b0;
            offset_reg     <= '0;
            tok_begin_reg  <= '0;
            name_begin_reg <= '0;
            name_end_reg   <= '0;
            val_begin_reg  <= '0;
            val_end_reg    <= '0;
            vmc_reg        <= '0;
            vmm_reg        <= 1'b0;
            finished_reg   <= 1'b1;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            offset_reg     <= offset_next;
            tok_begin_reg  <= tok_begin_next;
            name_begin_reg <= name_begin_next;
            name_end_reg   <= name_end_next;
            val_begin_reg  <= val_begin_next;
            val_end_reg    <= val_end_next;
            vmc_reg        <= vmc_next;
            vmm_reg        <= vmm_next;
            finished_reg   <= finished_next;
        end
    end

    always_comb
    begin
        phase_next      = cur_phase;
        kind_next       = cur_kind;
        offset_next     = off;
        tok_begin_next  = tok_begin_reg;
        name_begin_next = name_begin_reg;
        name_end_next   = name_end_reg;
        val_begin_next  = val_begin_reg;
        val_end_next    = val_end_reg;
        vmc_next        = cur_vmc;
        vmm_next        = cur_vmm;
        done            = 1'b0;
        pcnt            = 2'd0;
        res0            = mk_result(TK_REJECT, 16'd0, 16'd0);
        res1            = mk_result(TK_REJECT, 16'd0, 16'd0);

        case (cur_phase)
            PH_START:
            begin
                tok_begin_next = off;
                if (!cur_kind)
                begin
                    if (!is_upper)
                    begin
                        pcnt = 2'd1;
                        done = 1'b1;
                    end
                    else
                        phase_next = PH_METHOD;
                end
                else if (data_byte != CH_H)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
                else
                begin
                    vmc_next   = 4'd1;
                    vmm_next   = 1'b0;
                    phase_next = PH_VERSION;
                end
            end
            PH_METHOD:
            begin
                if (data_byte == CH_SP)
                begin
                    res0       = mk_result(TK_METHOD, tok_begin_reg, off - tok_begin_reg);
                    pcnt       = 2'd1;
                    phase_next = PH_SP_URI;
                end
                else if (!is_upper)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
            end
            PH_SP_URI:
            begin
                tok_begin_next = off;
                phase_next     = PH_URI;
            end
            PH_URI:
            begin
                if (data_byte == CH_SP)
                begin
                    res0       = mk_result(TK_URI, tok_begin_reg, off - tok_begin_reg);
                    pcnt       = 2'd1;
                    phase_next = PH_SP_VER;
                end
            end
            PH_SP_VER:
            begin
                tok_begin_next = off;
                vmc_next       = (data_byte == CH_H) ? 4'd1 : 4'd0;
                vmm_next       = (data_byte != CH_H);
                phase_next     = PH_VERSION;
            end
            PH_VERSION:
            begin
                if ((!cur_kind && data_byte == CH_CR) || (cur_kind && data_byte == CH_SP))
                begin
                    pcnt = 2'd1;
                    if (!ver_ok)
                        done = 1'b1;
                    else
                    begin
                        res0 = mk_result(TK_VERSION, tok_begin_reg, off - tok_begin_reg);
                        phase_next = cur_kind ? PH_SP_STATUS : PH_START_LF;
                    end
                end
                else
                begin
                    vmc_next = feed_vmc;
                    vmm_next = feed_vmm;
                end
            end
            PH_START_LF:
            begin
                if (data_byte != CH_LF)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
                else
                    phase_next = PH_NAME_START;
            end
            PH_SP_STATUS:
            begin
                if (!is_digit)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
                else
                begin
                    tok_begin_next = off;
                    phase_next     = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (data_byte == CH_SP)
                begin
                    res0       = mk_result(TK_STATUS, tok_begin_reg, off - tok_begin_reg);
                    pcnt       = 2'd1;
                    phase_next = PH_SP_REASON;
                end
                else if (!is_digit)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
            end
            PH_SP_REASON:
            begin
                tok_begin_next = off;
                if (data_byte == CH_CR)
                begin
                    // empty reason
                    res0       = mk_result(TK_REASON, off, 16'd0);
                    pcnt       = 2'd1;
                    phase_next = PH_START_LF;
                end
                else
                    phase_next = PH_REASON;
            end
            PH_REASON:
            begin
                if (data_byte == CH_CR)
                begin
                    res0       = mk_result(TK_REASON, tok_begin_reg, off - tok_begin_reg);
                    pcnt       = 2'd1;
                    phase_next = PH_START_LF;
                end
            end
            PH_NAME_START:
            begin
                if (data_byte == CH_COLON)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
                else if (data_byte == CH_CR)
                    phase_next = PH_HEAD_LF;
                else if (data_byte != CH_SP)
                begin
                    name_begin_next = off;
                    name_end_next   = off;
                    phase_next      = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (data_byte == CH_COLON)
                    phase_next = PH_VALUE_START;
                else if (data_byte != CH_SP)
                    name_end_next = off;
            end
            PH_VALUE_START:
            begin
                if (data_byte != CH_SP)
                begin
                    val_begin_next = off;
                    val_end_next   = off;
                    phase_next     = (data_byte == CH_CR) ? PH_LINE_LF : PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (data_byte != CH_SP)
                    val_end_next = off;
                if (data_byte == CH_CR)
                    phase_next = PH_LINE_LF;
            end
            PH_LINE_LF:
            begin
                if (data_byte != CH_LF)
                begin
                    pcnt = 2'd1;
                    done = 1'b1;
                end
                else
                begin
                    res0 = mk_result(TK_NAME, name_begin_reg,
                                     name_end_reg - name_begin_reg + 16'd1);
                    res1 = mk_result(TK_VALUE, val_begin_reg, val_end_reg - val_begin_reg);
                    pcnt       = 2'd2;
                    phase_next = PH_NAME_START;
                end
            end
            PH_HEAD_LF:
            begin
                pcnt = 2'd1;
                done = 1'b1;
                if (data_byte == CH_LF)
                    res0 = mk_result(cur_kind ? TK_ACC_RSP : TK_ACC_REQ, 16'd0, 16'd0);
            end
            default:
            begin
                pcnt = 2'd1;
                done = 1'b1;
            end
        endcase

        // early end of the stream or of the offset range
        extra_rej = !done && (last_byte || (off == MAX_OFFSET));
        if (!done && !extra_rej)
            offset_next = off + 16'd1;
        finished_next = done || extra_rej;
    end

    always_comb
    begin
        bundle.res[0] = res0;
        bundle.res[1] = res1;
        bundle.res[2] = mk_result(TK_REJECT, 16'd0, 16'd0);
        if (extra_rej)
            bundle.res[pcnt] = mk_result(TK_REJECT, 16'd0, 16'd0);
        bundle.cnt = pcnt + {1'b0, extra_rej};
    end

    assign push = take && (bundle.cnt != 2'd0);

endmodule

FILE: design/htt_queue.sv
// short bundle queue between parser front end and output stage
// depends on htt_pkg and the assertion macro header
`include "http_header_tokenizer_core_defines.svh"
module htt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  htt_pkg::bundle_t   wr_bundle,
    input  logic               pop,
    output htt_pkg::bundle_t   rd_bundle,
    output htt_pkg::q_status_t status
);
    import htt_pkg::*;

    bundle_t            slots [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_bundle    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= wr_bundle;
    end

    `HTT_ASSERT_IMP(a_q_count_bound, 1'b1, count_reg <= QCNT_W'(QDEPTH), "queue count overrun")
    `HTT_ASSERT_IMP(a_q_no_overflow, push, !status.full || pop, "push into full queue")
    `HTT_ASSERT_IMP(a_q_no_underflow, pop, !status.empty, "pop from empty queue")

endmodule

FILE: design/htt_back.sv
// output stage: walks each queued bundle one result per transaction
// depends on htt_pkg and the assertion macro header
`include "http_header_tokenizer_core_defines.svh"
module htt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  htt_pkg::bundle_t   head,
    input  htt_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         token_kind,
    output logic [15:0]        span_start,
    output logic [15:0]        span_length,
    output logic               last_of_run
);
    import htt_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    result_t     res_reg;
    logic        last_reg;
    logic        load;
    logic        at_last;

    assign load    = !q_status.empty && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.cnt - 2'd1);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.res[idx_reg];
            last_reg <= at_last;
        end
    end

    assign out_valid   = valid_reg;
    assign token_kind  = res_reg.kind;
    assign span_start  = res_reg.start;
    assign span_length = res_reg.length;
    assign last_of_run = last_reg;

    `HTT_ASSERT_IMP(a_back_idx_idle, q_status.empty, idx_reg == 2'd0, "stale result index")
    `HTT_ASSERT_NXT(a_back_load_shows, load, valid_reg, "loaded result not presented")

endmodule

FILE: design/http_header_tokenizer_core.sv
// top level of the http/1.1 header tokenizer
// depends on htt_pkg, htt_front, htt_queue and htt_back
// usage:
//   slave side takes one message byte per transaction: s_tdata is the byte,
//   s_tuser[0] flags the first byte of a message (restarts the parse),
//   s_tuser[1] gives the message kind on that first byte (0 request,
//   1 response), s_tlast flags the last byte that is available.
//   master side gives token spans and verdicts: m_tuser is the token kind,
//   m_tdata holds span start (low half) and span length (high half),
//   m_tlast marks the last result caused by one input byte.
// throughput: one byte per cycle while s_tready is high. a byte that ends a
//   header line gives two results, and the output register drains one result
//   per cycle while m_tready is high, so the four-bundle queue absorbs the
//   extra results of those bytes.
// path: the bundle enters the queue when the byte's transaction completes; the
//   output register then loads it from the queue and m_tvalid rises.
// stall: when m_tready is low the output register holds its transaction,
//   the queue fills, and s_tready drops once all four queue slots are taken.
// reset: the parser goes idle and ignores bytes until a first-byte flag; the
//   queue and output register are emptied.
module http_header_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] first_byte, [1] kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] span_start, [31:16] span_length
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast
);
    import htt_pkg::*;

    bundle_t     wr_bundle;
    bundle_t     rd_bundle;
    q_status_t   q_status;
    logic        push;
    logic        pop;
    logic [15:0] span_start;
    logic [15:0] span_length;

    // parse one byte per cycle, while the queue has room, into a bundle of results
    htt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .first_byte (s_tuser[0]),
        .last_byte  (s_tlast),
        .kind       (s_tuser[1]),
        .q_status   (q_status),
        .push       (push),
        .bundle     (wr_bundle)
    );

    // decouples parser from output stalls
    htt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (wr_bundle),
        .pop       (pop),
        .rd_bundle (rd_bundle),
        .status    (q_status)
    );

    // one result per master transaction
    htt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (rd_bundle),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .token_kind  (m_tuser),
        .span_start  (span_start),
        .span_length (span_length),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {span_length, span_start};

endmodule
